[rtl/rrc_ota_wrapper_header_parser_unit_macros.svh]
// Assertion macros shared by the header parser RTL.
`ifndef RRC_OTA_WRAPPER_HEADER_PARSER_UNIT_MACROS_SVH
`define RRC_OTA_WRAPPER_HEADER_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ROHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ROHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rohp_pkg.sv]
// Package: layout table, status codes and decode helpers for the header parser.
package rohp_pkg;

  localparam int unsigned POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic CFG_CELL_ID_LIMIT = 1'b0;
  localparam logic CFG_CHANNEL_LIMIT = 1'b1;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_UNSUPPORTED = 3'd1;
  localparam logic [2:0] STATUS_SHORT       = 3'd2;
  localparam logic [2:0] STATUS_OVERRUN     = 3'd3;
  localparam logic [2:0] STATUS_RANGE       = 3'd4;

  localparam logic [2:0] LAYOUT_NONE   = 3'd0;
  localparam logic [2:0] LAYOUT_BASIC  = 3'd1;
  localparam logic [2:0] LAYOUT_WIDECH = 3'd2;
  localparam logic [2:0] LAYOUT_NR4    = 3'd3;
  localparam logic [2:0] LAYOUT_NR5    = 3'd4;
  localparam logic [2:0] LAYOUT_LONG   = 3'd5;

  localparam logic [7:0] KIND_MASK_TOP = 8'h28;
  localparam logic [7:0] KIND_MASK     = 8'h1F;

  localparam logic [15:0] CELL_ID_LIMIT_RST = 16'd1007;
  localparam logic [31:0] CHANNEL_LIMIT_RST = 32'h1000_0000;

  typedef struct packed {
    logic [4:0] rrc;
    logic [4:0] nr;
    logic [4:0] rb;
    logic [4:0] pci;
    logic [4:0] ch;
    logic       ch4;
    logic [4:0] sfn;
    logic       shift5;
    logic [4:0] typ;
    logic [4:0] len;
    logic [4:0] hdr;
    logic       add;
  } layout_t;

  localparam layout_t LAYOUTS [0:5] = '{
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 1'b0, 5'd0,  1'b0, 5'd0,  5'd0,  5'd0,  1'b0},
    '{5'd1, 5'd0, 5'd2, 5'd3, 5'd5, 1'b0, 5'd7,  1'b0, 5'd9,  5'd10, 5'd12, 1'b0},
    '{5'd1, 5'd0, 5'd2, 5'd3, 5'd5, 1'b1, 5'd9,  1'b0, 5'd11, 5'd12, 5'd14, 1'b0},
    '{5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 1'b1, 5'd10, 1'b0, 5'd12, 5'd13, 5'd15, 1'b0},
    '{5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 1'b1, 5'd10, 1'b1, 5'd12, 5'd13, 5'd15, 1'b0},
    '{5'd1, 5'd2, 5'd3, 5'd6, 5'd8, 1'b1, 5'd12, 1'b0, 5'd18, 5'd19, 5'd21, 1'b1}
  };

  function automatic logic [2:0] layout_index(input logic [7:0] v);
    logic [2:0] li;
    unique case (v) inside
      8'h02, 8'h03, 8'h04, 8'h06, 8'h07, 8'h08:              li = LAYOUT_BASIC;
      8'h0B:                                                li = LAYOUT_WIDECH;
      8'h09, [8'h0C:8'h10], 8'h13, 8'h14, 8'h16:            li = LAYOUT_NR4;
      [8'h18:8'h1A]:                                        li = LAYOUT_NR5;
      [8'h1B:8'h23]:                                        li = LAYOUT_LONG;
      default:                                              li = LAYOUT_NONE;
    endcase
    return li;
  endfunction

  // Offset the raw type, fold the upper band down, keep only canonical kinds.
  function automatic logic [3:0] kind_of(input logic [7:0] raw, input logic add);
    logic [7:0] v;
    v = raw + {7'd0, add};
    if (v > 8'd8 && v <= KIND_MASK_TOP) begin
      v = v & KIND_MASK;
    end
    return (v >= 8'd1 && v <= 8'd8) ? v[3:0] : 4'd0;
  endfunction

  function automatic logic pos_hit(input logic [POS_W-1:0] p, input logic [4:0] off);
    return p == POS_W'(off);
  endfunction

endpackage

[rtl/rohp_in_if.sv]
// Interface: byte channel into the header parser.
interface rohp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

[rtl/rohp_out_if.sv]
// Interface: decoded header channel out of the header parser.
interface rohp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  version;
  logic [7:0]  radio_release;
  logic [7:0]  nr_release;
  logic [7:0]  bearer_id;
  logic [15:0] cell_id;
  logic [31:0] channel;
  logic [11:0] frame_number;
  logic [4:0]  subframe;
  logic [3:0]  message_kind;
  logic [15:0] payload_length;
  logic [4:0]  header_length;

  modport source (
    output valid, output status, output version, output radio_release, output nr_release,
    output bearer_id, output cell_id, output channel, output frame_number,
    output subframe, output message_kind, output payload_length, output header_length,
    input ready
  );
  modport sink (
    input valid, input status, input version, input radio_release, input nr_release,
    input bearer_id, input cell_id, input channel, input frame_number,
    input subframe, input message_kind, input payload_length, input header_length,
    output ready
  );
endinterface

[rtl/rrc_ota_wrapper_header_parser_unit.sv]
// Top level: byte-serial wrapper header parser with one result per packet.
//
// Usage: bytes of one wrapper packet enter on in_chan, one byte per item, the
// version byte first; end_of_packet marks the final byte. For every packet one
// item leaves on out_chan carrying the status and the decoded header fields.
// Limits for the range check are written through cfg_we/cfg_index/cfg_wdata
// (index 0 cell id limit, index 1 channel limit) while the parser is idle.
//
// Throughput: one byte per cycle across packets while out_chan drains.
// Path: the final byte goes straight into the snapshot with the field
// registers; the layout decode and the length and range compares then load
// the result register.
// Stall: when out_chan.ready is low the result register holds, the snapshot
// holds behind it, and in_chan.ready drops only once both are occupied; bytes
// of a following packet keep flowing into the field registers meanwhile.
// Reset (rst_n low, synchronous): byte count and all field registers clear,
// both stages empty, limits return to 1007 and 0x10000000.
`include "rrc_ota_wrapper_header_parser_unit_macros.svh"

module rrc_ota_wrapper_header_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  rohp_in_if.sink     in_chan,
  rohp_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import rohp_pkg::*;

  // Configuration registers
  logic [15:0] cell_lim_r;
  logic [31:0] chan_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_lim_r <= CELL_ID_LIMIT_RST;
      chan_lim_r <= CHANNEL_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CELL_ID_LIMIT) begin
        cell_lim_r <= cfg_wdata[15:0];
      end else begin
        chan_lim_r <= cfg_wdata;
      end
    end
  end

  // Handshake across the two stages
  logic snap_v_r, out_v_r;
  logic out_free, snap_free, in_fire;

  assign out_free  = !out_v_r || out_chan.ready;
  assign snap_free = !snap_v_r || out_free;
  assign in_chan.ready = snap_free;
  assign in_fire = in_chan.valid && snap_free;

  // Packet field registers, filled as the bytes go by
  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [7:0]  ver_r, ver_nxt, rrc_r, rrc_nxt, nr_r, nr_nxt, rb_r, rb_nxt;
  logic [7:0]  kraw_r, kraw_nxt;
  logic [15:0] cell_r, cell_nxt, frame_r, frame_nxt, len_r, len_nxt;
  logic [31:0] chan_r, chan_nxt;
  layout_t     lay_cap;
  logic [7:0]  b;

  assign b       = in_chan.data_byte;
  assign lay_cap = LAYOUTS[layout_index(ver_r)];
  assign pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);

  // Captured view of the packet including the byte being taken now
  always_comb begin
    ver_nxt   = ver_r;
    rrc_nxt   = rrc_r;
    nr_nxt    = nr_r;
    rb_nxt    = rb_r;
    cell_nxt  = cell_r;
    chan_nxt  = chan_r;
    frame_nxt = frame_r;
    kraw_nxt  = kraw_r;
    len_nxt   = len_r;
    if (pos_r == '0) begin
      ver_nxt = b;
    end else if (layout_index(ver_r) != LAYOUT_NONE) begin
      if (pos_hit(pos_r, lay_cap.rrc)) rrc_nxt = b;
      if (lay_cap.nr != 5'd0 && pos_hit(pos_r, lay_cap.nr)) nr_nxt = b;
      if (pos_hit(pos_r, lay_cap.rb)) rb_nxt = b;
      if (pos_hit(pos_r, lay_cap.pci)) cell_nxt[7:0] = b;
      if (pos_hit(pos_r, lay_cap.pci + 5'd1)) cell_nxt[15:8] = b;
      if (pos_hit(pos_r, lay_cap.ch)) chan_nxt[7:0] = b;
      if (pos_hit(pos_r, lay_cap.ch + 5'd1)) chan_nxt[15:8] = b;
      if (lay_cap.ch4 && pos_hit(pos_r, lay_cap.ch + 5'd2)) chan_nxt[23:16] = b;
      if (lay_cap.ch4 && pos_hit(pos_r, lay_cap.ch + 5'd3)) chan_nxt[31:24] = b;
      if (pos_hit(pos_r, lay_cap.sfn)) frame_nxt[7:0] = b;
      if (pos_hit(pos_r, lay_cap.sfn + 5'd1)) frame_nxt[15:8] = b;
      if (pos_hit(pos_r, lay_cap.typ)) kraw_nxt = b;
      if (pos_hit(pos_r, lay_cap.len)) len_nxt[7:0] = b;
      if (pos_hit(pos_r, lay_cap.len + 5'd1)) len_nxt[15:8] = b;
    end
    pos_nxt = pos_inc;
  end

  // Advance on each byte; drop all packet state after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ver_r   <= '0;
      rrc_r   <= '0;
      nr_r    <= '0;
      rb_r    <= '0;
      cell_r  <= '0;
      chan_r  <= '0;
      frame_r <= '0;
      kraw_r  <= '0;
      len_r   <= '0;
    end else if (in_fire) begin
      if (in_chan.end_of_packet) begin
        pos_r   <= '0;
        ver_r   <= '0;
        rrc_r   <= '0;
        nr_r    <= '0;
        rb_r    <= '0;
        cell_r  <= '0;
        chan_r  <= '0;
        frame_r <= '0;
        kraw_r  <= '0;
        len_r   <= '0;
      end else begin
        pos_r   <= pos_nxt;
        ver_r   <= ver_nxt;
        rrc_r   <= rrc_nxt;
        nr_r    <= nr_nxt;
        rb_r    <= rb_nxt;
        cell_r  <= cell_nxt;
        chan_r  <= chan_nxt;
        frame_r <= frame_nxt;
        kraw_r  <= kraw_nxt;
        len_r   <= len_nxt;
      end
    end
  end

  // Snapshot of a finished packet, waiting for the decode stage
  logic [POS_W-1:0] s_cnt_r;
  logic [7:0]  s_ver_r, s_rrc_r, s_nr_r, s_rb_r, s_kraw_r;
  logic [15:0] s_cell_r, s_frame_r, s_len_r;
  logic [31:0] s_chan_r;
  logic        snap_load;

  assign snap_load = in_fire && in_chan.end_of_packet;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else if (snap_free) begin
      snap_v_r <= snap_load;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      s_cnt_r   <= pos_nxt;
      s_ver_r   <= ver_nxt;
      s_rrc_r   <= rrc_nxt;
      s_nr_r    <= nr_nxt;
      s_rb_r    <= rb_nxt;
      s_cell_r  <= cell_nxt;
      s_chan_r  <= chan_nxt;
      s_frame_r <= frame_nxt;
      s_kraw_r  <= kraw_nxt;
      s_len_r   <= len_nxt;
    end
  end

  // Decode stage: layout, status and field formatting
  logic [2:0]       s_li;
  layout_t          lay_s;
  logic [POS_W-1:0] need;
  logic [2:0]       st_nxt;
  logic [7:0]       rrc_o, nr_o, rb_o;
  logic [15:0]      cell_o, len_o;
  logic [31:0]      chan_o;
  logic [11:0]      fn_o;
  logic [4:0]       sf_o, hdr_o;
  logic [3:0]       kind_o;

  assign s_li  = layout_index(s_ver_r);
  assign lay_s = LAYOUTS[s_li];
  assign need  = POS_W'(lay_s.hdr) + POS_W'(s_len_r);

  always_comb begin
    st_nxt = STATUS_OK;
    rrc_o  = '0;
    nr_o   = '0;
    rb_o   = '0;
    cell_o = '0;
    chan_o = '0;
    fn_o   = '0;
    sf_o   = '0;
    kind_o = '0;
    len_o  = '0;
    hdr_o  = '0;
    if (s_li == LAYOUT_NONE) begin
      st_nxt = STATUS_UNSUPPORTED;
    end else if (s_cnt_r < POS_W'(lay_s.hdr)) begin
      st_nxt = STATUS_SHORT;
      hdr_o  = lay_s.hdr;
    end else begin
      if (need > s_cnt_r) begin
        st_nxt = STATUS_OVERRUN;
      end else if (s_cell_r > cell_lim_r || s_chan_r > chan_lim_r) begin
        st_nxt = STATUS_RANGE;
      end
      rrc_o  = s_rrc_r;
      nr_o   = (lay_s.nr != 5'd0) ? s_nr_r : 8'd0;
      rb_o   = s_rb_r;
      cell_o = s_cell_r;
      chan_o = s_chan_r;
      if (lay_s.shift5) begin
        fn_o = {1'b0, s_frame_r[15:5]};
        sf_o = s_frame_r[4:0];
      end else begin
        fn_o = s_frame_r[15:4];
        sf_o = {1'b0, s_frame_r[3:0]};
      end
      kind_o = kind_of(s_kraw_r, lay_s.add);
      len_o  = s_len_r;
      hdr_o  = lay_s.hdr;
    end
  end

  // Result register
  logic [2:0]  o_st_r;
  logic [7:0]  o_ver_r, o_rrc_r, o_nr_r, o_rb_r;
  logic [15:0] o_cell_r, o_len_r;
  logic [31:0] o_chan_r;
  logic [11:0] o_fn_r;
  logic [4:0]  o_sf_r, o_hdr_r;
  logic [3:0]  o_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= snap_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && snap_v_r) begin
      o_st_r   <= st_nxt;
      o_ver_r  <= s_ver_r;
      o_rrc_r  <= rrc_o;
      o_nr_r   <= nr_o;
      o_rb_r   <= rb_o;
      o_cell_r <= cell_o;
      o_chan_r <= chan_o;
      o_fn_r   <= fn_o;
      o_sf_r   <= sf_o;
      o_kind_r <= kind_o;
      o_len_r  <= len_o;
      o_hdr_r  <= hdr_o;
    end
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.status         = o_st_r;
  assign out_chan.version        = o_ver_r;
  assign out_chan.radio_release  = o_rrc_r;
  assign out_chan.nr_release     = o_nr_r;
  assign out_chan.bearer_id      = o_rb_r;
  assign out_chan.cell_id        = o_cell_r;
  assign out_chan.channel        = o_chan_r;
  assign out_chan.frame_number   = o_fn_r;
  assign out_chan.subframe       = o_sf_r;
  assign out_chan.message_kind   = o_kind_r;
  assign out_chan.payload_length = o_len_r;
  assign out_chan.header_length  = o_hdr_r;

  // Checks
  `ROHP_ASSERT_NEXT(a_last_fills_snap, snap_load, snap_v_r,
                    "final byte did not reach the snapshot stage")
  `ROHP_ASSERT_NEXT(a_last_clears_count, snap_load, pos_r == '0,
                    "byte count not cleared after the final byte")
  `ROHP_ASSERT_NEXT(a_mid_byte_counts, in_fire && !in_chan.end_of_packet, pos_r != '0,
                    "byte count failed to advance within a packet")
  `ROHP_ASSERT_NEXT(a_snap_kept, snap_v_r && !out_free, snap_v_r,
                    "pending packet snapshot lost during output stall")
  `ROHP_ASSERT_NOW(a_status_legal, out_v_r, o_st_r <= STATUS_RANGE,
                   "result status outside the defined codes")

endmodule

[dv/rrc_ota_wrapper_header_parser_unit_tb.sv]
// Self-checking testbench for the byte-serial wrapper header parser.
`timescale 1ns / 100ps

module rrc_ota_wrapper_header_parser_unit_tb;
  import rohp_pkg::*;

  localparam int HOLD_CYCLES   = 300;      // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;        // margin for the result to land after the last byte
  localparam int TIMEOUT_NS    = 200_000;

  // Header layout as seen by the checker: byte offsets of each field.
  typedef struct {
    int rrc_at;
    int nr_at;
    int rb_at;
    int pci_at;
    int ch_at;
    int ch_n;
    int sfn_at;
    int sh5;
    int typ_at;
    int len_at;
    int hdr;
    int add;
  } fmt_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  version;
    logic [7:0]  radio_release;
    logic [7:0]  nr_release;
    logic [7:0]  bearer_id;
    logic [15:0] cell_id;
    logic [31:0] channel;
    logic [11:0] frame_number;
    logic [4:0]  subframe;
    logic [3:0]  message_kind;
    logic [15:0] payload_length;
    logic [4:0]  header_length;
  } hdr_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_TAME} fill_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  rohp_in_if  byte_if ();
  rohp_out_if hdr_if ();

  rrc_ota_wrapper_header_parser_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (byte_if),
    .out_chan  (hdr_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Bytes waiting to be offered, and decoded headers waiting to come out.
  wire_byte_t wire_bytes [$];
  hdr_t       decoded_headers_q [$];

  // Checker's own copy of the packet state and the limit registers.
  logic [16:0] pos      = '0;
  logic [7:0]  ver      = '0;
  logic [7:0]  rrc_b    = '0;
  logic [7:0]  nr_b     = '0;
  logic [7:0]  rb_b     = '0;
  logic [15:0] pci      = '0;
  logic [31:0] chn      = '0;
  logic [15:0] sfn_raw  = '0;
  logic [7:0]  kind_raw = '0;
  logic [15:0] plen     = '0;
  logic [15:0] lim_cell = 16'd1007;
  logic [31:0] lim_ch   = 32'h1000_0000;

  logic no_gaps;
  logic rx_hold;
  event rx_hold_ev;

  int mismatches     = 0;
  int results_seen   = 0;
  int bytes_taken    = 0;
  int bytes_queued   = 0;
  int packets_queued = 0;
  int limit_settings = 1;
  int status_hits [0:7] = '{default: 0};

  // Clock: 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic fmt_t fmt_for(input logic [7:0] v);
    fmt_t f;
    case (v)
      8'h02, 8'h03, 8'h04, 8'h06, 8'h07, 8'h08:
        f = '{1, 0, 2, 3, 5, 2, 7, 0, 9, 10, 12, 0};
      8'h0B:
        f = '{1, 0, 2, 3, 5, 4, 9, 0, 11, 12, 14, 0};
      8'h09, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h13, 8'h14, 8'h16:
        f = '{1, 2, 3, 4, 6, 4, 10, 0, 12, 13, 15, 0};
      8'h18, 8'h19, 8'h1A:
        f = '{1, 2, 3, 4, 6, 4, 10, 1, 12, 13, 15, 0};
      default: begin
        if (v >= 8'h1B && v <= 8'h23) begin
          f = '{1, 2, 3, 6, 8, 4, 12, 0, 18, 19, 21, 1};
        end else begin
          f = '{default: 0};
        end
      end
    endcase
    return f;
  endfunction

  // Offset the raw type, fold 9..0x28 down by the five-bit mask, keep only 1..8.
  function automatic logic [3:0] canon_kind(input logic [7:0] raw, input int add);
    logic [7:0] k;
    k = raw + 8'(add);
    if (k > 8'd8 && k <= 8'h28) begin
      k = k & 8'h1F;
    end
    return (k >= 8'd1 && k <= 8'd8) ? k[3:0] : 4'd0;
  endfunction

  // Advance the checker by one accepted byte; queue the decoded header on the last one.
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    fmt_t f;
    hdr_t r;
    int   p;
    p = int'(pos);
    bytes_taken++;
    if (p == 0) begin
      ver = b;
    end else begin
      f = fmt_for(ver);
      if (f.hdr != 0) begin
        if (p == f.rrc_at) rrc_b = b;
        if (f.nr_at != 0 && p == f.nr_at) nr_b = b;
        if (p == f.rb_at) rb_b = b;
        if (p >= f.pci_at && p < f.pci_at + 2) pci[8*(p - f.pci_at) +: 8] = b;
        if (p >= f.ch_at && p < f.ch_at + f.ch_n) chn[8*(p - f.ch_at) +: 8] = b;
        if (p >= f.sfn_at && p < f.sfn_at + 2) sfn_raw[8*(p - f.sfn_at) +: 8] = b;
        if (p == f.typ_at) kind_raw = b;
        if (p >= f.len_at && p < f.len_at + 2) plen[8*(p - f.len_at) +: 8] = b;
      end
    end
    // saturate rather than wrap
    if (pos != '1) pos = pos + 17'd1;
    if (!last) return;

    f = fmt_for(ver);
    r = '0;
    r.version = ver;
    if (f.hdr == 0) begin
      r.status = STATUS_UNSUPPORTED;
    end else if (int'(pos) < f.hdr) begin
      r.status        = STATUS_SHORT;
      r.header_length = 5'(f.hdr);
    end else begin
      if (f.hdr + int'(plen) > int'(pos)) begin
        r.status = STATUS_OVERRUN;
      end else if (pci > lim_cell || chn > lim_ch) begin
        r.status = STATUS_RANGE;
      end else begin
        r.status = STATUS_OK;
      end
      r.radio_release = rrc_b;
      r.nr_release    = (f.nr_at != 0) ? nr_b : 8'd0;
      r.bearer_id     = rb_b;
      r.cell_id       = pci;
      r.channel       = chn;
      if (f.sh5 != 0) begin
        r.frame_number = {1'b0, sfn_raw[15:5]};
        r.subframe     = sfn_raw[4:0];
      end else begin
        r.frame_number = sfn_raw[15:4];
        r.subframe     = {1'b0, sfn_raw[3:0]};
      end
      r.message_kind   = canon_kind(kind_raw, f.add);
      r.payload_length = plen;
      r.header_length  = 5'(f.hdr);
    end
    decoded_headers_q.push_back(r);
    status_hits[r.status]++;

    // packet done: drop all packet state
    pos      = '0;
    ver      = '0;
    rrc_b    = '0;
    nr_b     = '0;
    rb_b     = '0;
    pci      = '0;
    chn      = '0;
    sfn_raw  = '0;
    kind_raw = '0;
    plen     = '0;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
               results_seen, what, want, got);
    end
  endtask

  task automatic compare_header(input hdr_t want, input hdr_t got);
    if (got.status != want.status) flag_mismatch("status", want.status, got.status);
    if (got.version != want.version) flag_mismatch("version", want.version, got.version);
    if (got.radio_release != want.radio_release)
      flag_mismatch("radio_release", want.radio_release, got.radio_release);
    if (got.nr_release != want.nr_release)
      flag_mismatch("nr_release", want.nr_release, got.nr_release);
    if (got.bearer_id != want.bearer_id)
      flag_mismatch("bearer_id", want.bearer_id, got.bearer_id);
    if (got.cell_id != want.cell_id) flag_mismatch("cell_id", want.cell_id, got.cell_id);
    if (got.channel != want.channel) flag_mismatch("channel", want.channel, got.channel);
    if (got.frame_number != want.frame_number)
      flag_mismatch("frame_number", want.frame_number, got.frame_number);
    if (got.subframe != want.subframe)
      flag_mismatch("subframe", want.subframe, got.subframe);
    if (got.message_kind != want.message_kind)
      flag_mismatch("message_kind", want.message_kind, got.message_kind);
    if (got.payload_length != want.payload_length)
      flag_mismatch("payload_length", want.payload_length, got.payload_length);
    if (got.header_length != want.header_length)
      flag_mismatch("header_length", want.header_length, got.header_length);
  endtask

  // Sender: take the byte on an accepting edge, then offer the next one or idle.
  always @(posedge clk) begin : byte_driver
    wire_byte_t nb;
    if (!rst_n) begin
      byte_if.valid <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        absorb_byte(byte_if.data_byte, byte_if.end_of_packet);
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (wire_bytes.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 10)) begin
          nb = wire_bytes.pop_front();
          byte_if.data_byte     <= nb.data;
          byte_if.end_of_packet <= nb.last;
          byte_if.valid         <= 1'b1;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each header against the oldest prediction, stall at random.
  always @(posedge clk) begin : header_monitor
    hdr_t got;
    if (!rst_n) begin
      hdr_if.ready <= 1'b0;
    end else begin
      if (hdr_if.valid && hdr_if.ready) begin
        got.status         = hdr_if.status;
        got.version        = hdr_if.version;
        got.radio_release  = hdr_if.radio_release;
        got.nr_release     = hdr_if.nr_release;
        got.bearer_id      = hdr_if.bearer_id;
        got.cell_id        = hdr_if.cell_id;
        got.channel        = hdr_if.channel;
        got.frame_number   = hdr_if.frame_number;
        got.subframe       = hdr_if.subframe;
        got.message_kind   = hdr_if.message_kind;
        got.payload_length = hdr_if.payload_length;
        got.header_length  = hdr_if.header_length;
        if (decoded_headers_q.size() == 0) begin
          flag_mismatch("header with none pending, version", 32'd0, got.version);
        end else begin
          compare_header(decoded_headers_q.pop_front(), got);
        end
        results_seen++;
      end
      hdr_if.ready <= !rx_hold && (no_gaps || $urandom_range(0, 99) >= 10);
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering bytes.
  initial begin : hold_off
    rx_hold = 1'b0;
    forever begin
      @(rx_hold_ev);
      @(posedge clk);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  function automatic void put_le(ref logic [7:0] pkt[$], input int at, input int n,
                                 input logic [31:0] val);
    for (int i = 0; i < n; i++) begin
      if (at + i < pkt.size()) pkt[at + i] = val[8*i +: 8];
    end
  endfunction

  // Build one packet; plen and kind of -1 leave those bytes as filled.
  task automatic queue_packet(input logic [7:0] ver_b, input int total, input int len_val,
                              input int kind, input fill_e fill);
    fmt_t        f;
    logic [7:0]  pkt [$];
    logic [31:0] ch_cap;
    wire_byte_t  wb;
    f = fmt_for(ver_b);
    for (int i = 0; i < total; i++) begin
      case (fill)
        FILL_ZERO: pkt.push_back(8'h00);
        FILL_ONES: pkt.push_back(8'hFF);
        default:   pkt.push_back(8'($urandom));
      endcase
    end
    pkt[0] = ver_b;
    if (fill == FILL_TAME && f.hdr != 0) begin
      // keep cell id and channel within the current limits, often right on them
      ch_cap = (f.ch_n == 2 && lim_ch > 32'hFFFF) ? 32'hFFFF : lim_ch;
      put_le(pkt, f.pci_at, 2,
             ($urandom_range(0, 3) == 0) ? 32'(lim_cell) : $urandom_range(0, lim_cell));
      put_le(pkt, f.ch_at, f.ch_n,
             ($urandom_range(0, 3) == 0) ? ch_cap : $urandom_range(0, ch_cap));
      if ($urandom_range(0, 1) == 1) put_le(pkt, f.typ_at, 1, $urandom_range(0, 8'h2A));
    end
    if (len_val >= 0 && f.hdr != 0) put_le(pkt, f.len_at, 2, len_val);
    if (kind >= 0 && f.hdr != 0) put_le(pkt, f.typ_at, 1, kind);
    foreach (pkt[i]) begin
      wb.data = pkt[i];
      wb.last = (i == pkt.size() - 1);
      wire_bytes.push_back(wb);
    end
    bytes_queued += total;
    packets_queued++;
  endtask

  // Mostly well-formed packets with random content; the rest broken or noise.
  task automatic queue_random_packet();
    int         r;
    int         hdr;
    int         total;
    int         len_val;
    logic [7:0] v;
    fmt_t       f;
    fill_e      fill;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      do begin
        v = 8'($urandom_range(0, 8'h23));
        f = fmt_for(v);
      end while (f.hdr == 0);
    end else begin
      do begin
        v = 8'($urandom);
        f = fmt_for(v);
      end while (f.hdr != 0);
    end
    hdr     = (f.hdr != 0) ? f.hdr : 12;
    len_val = -1;
    fill    = FILL_RANDOM;
    if (r < 55) begin
      len_val = $urandom_range(0, 8);
      total   = hdr + len_val + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      fill    = ($urandom_range(0, 4) != 0) ? FILL_TAME : FILL_RANDOM;
    end else if (r < 65) begin
      // length field points past the end of the packet
      len_val = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 20) : $urandom_range(1, 65535);
      total   = hdr + $urandom_range(0, (len_val - 1 < 10) ? len_val - 1 : 10);
      fill    = ($urandom_range(0, 1) == 1) ? FILL_TAME : FILL_RANDOM;
    end else if (r < 72) begin
      total = $urandom_range(1, hdr - 1);
    end else begin
      total = $urandom_range(1, 30);
    end
    queue_packet(v, total, len_val, -1, fill);
  endtask

  task automatic queue_random_phase(input int min_bytes, input int min_packets);
    int b0;
    int p0;
    b0 = bytes_queued;
    p0 = packets_queued;
    while (bytes_queued - b0 < min_bytes || packets_queued - p0 < min_packets) begin
      queue_random_packet();
    end
  endtask

  // Hold the sender until every byte is in and every header is out, then let
  // the pipeline drain past its latency.
  task automatic settle_block();
    do @(negedge clk);
    while (wire_bytes.size() != 0 || byte_if.valid || decoded_headers_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_CELL_ID_LIMIT) lim_cell = val[15:0];
    else lim_ch = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_CELL_ID_LIMIT;
    cfg_wdata             = '0;
    byte_if.valid         = 1'b0;
    byte_if.data_byte     = '0;
    byte_if.end_of_packet = 1'b0;
    hdr_if.ready          = 1'b0;
    no_gaps               = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every layout with zero, all-ones or tame fields, at the reset limits.
    queue_packet(8'h02, 12, 0, -1, FILL_ZERO);
    queue_packet(8'h08, 12, 0, -1, FILL_ONES);   // cell id all ones: out of range
    queue_packet(8'h0B, 14, 0, -1, FILL_ONES);   // wide channel all ones
    queue_packet(8'h09, 15, 0, -1, FILL_ZERO);
    queue_packet(8'h16, 17, 2, -1, FILL_TAME);
    queue_packet(8'h18, 15, 0, -1, FILL_ONES);   // five-bit subframe split
    queue_packet(8'h1A, 16, 1, -1, FILL_TAME);
    queue_packet(8'h1B, 21, 0, -1, FILL_ONES);   // type 0xFF plus one wraps to unknown
    queue_packet(8'h23, 24, 3, -1, FILL_TAME);
    // message kind folding around its band edges
    queue_packet(8'h02, 12, 0, 8'h08, FILL_TAME);
    queue_packet(8'h03, 12, 0, 8'h09, FILL_TAME);
    queue_packet(8'h04, 12, 0, 8'h28, FILL_TAME);
    queue_packet(8'h06, 12, 0, 8'h29, FILL_TAME);
    queue_packet(8'h07, 12, 0, 8'h21, FILL_TAME);
    queue_packet(8'h20, 21, 0, 8'h27, FILL_TAME);
    // unsupported versions
    queue_packet(8'h00, 1, -1, -1, FILL_RANDOM);
    queue_packet(8'hFF, 5, -1, -1, FILL_ONES);
    queue_packet(8'h24, 21, -1, -1, FILL_RANDOM);
    queue_packet(8'h05, 12, -1, -1, FILL_ZERO);
    // short headers: version byte alone, one byte short
    queue_packet(8'h02, 1, -1, -1, FILL_RANDOM);
    queue_packet(8'h1F, 20, 0, -1, FILL_ZERO);
    queue_packet(8'h0B, 13, -1, -1, FILL_ONES);
    // length overrun, one byte and far past the end
    queue_packet(8'h0C, 15, 1, -1, FILL_TAME);
    queue_packet(8'h03, 12, 16'hFFFF, -1, FILL_TAME);
    settle_block();

    // Hold the receiver off while a burst of tiny packets piles up behind it.
    -> rx_hold_ev;
    repeat (30) begin
      queue_packet(8'($urandom_range(0, 8'h23)), $urandom_range(1, 3), -1, -1, FILL_RANDOM);
    end
    queue_random_phase(30, 2);
    settle_block();

    // Lowest limits, with neither side idling.
    write_limit(CFG_CELL_ID_LIMIT, 32'd0);
    write_limit(CFG_CHANNEL_LIMIT, 32'd0);
    limit_settings++;
    @(posedge clk);
    no_gaps <= 1'b1;
    @(negedge clk);
    queue_random_phase(60, 4);
    settle_block();
    @(posedge clk);
    no_gaps <= 1'b0;
    @(negedge clk);

    // Highest limits, with a length field far past the end of the packet.
    write_limit(CFG_CELL_ID_LIMIT, 32'h0000_FFFF);
    write_limit(CFG_CHANNEL_LIMIT, 32'hFFFF_FFFF);
    limit_settings++;
    queue_packet(8'h0B, 30, 16'hFFFF, -1, FILL_TAME);
    queue_random_phase(30, 2);
    settle_block();

    // Random limits around the usual cell id range.
    write_limit(CFG_CELL_ID_LIMIT, $urandom_range(500, 1500));
    write_limit(CFG_CHANNEL_LIMIT, $urandom);
    limit_settings++;
    queue_random_phase(30, 2);
    settle_block();

    $display("covered %0d packets, %0d bytes, under %0d limit settings",
             results_seen, bytes_taken, limit_settings);
    $display("outcomes: ok %0d, bad version %0d, short %0d, overrun %0d, out of range %0d",
             status_hits[STATUS_OK], status_hits[STATUS_UNSUPPORTED],
             status_hits[STATUS_SHORT], status_hits[STATUS_OVERRUN],
             status_hits[STATUS_RANGE]);
    if (mismatches == 0 && decoded_headers_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
